>>> hdl/great_circle_distance_top_macros.svh
// ----------------------------------------------------------------------------
// great_circle_distance_top_macros
// Assertion helpers for the great-circle distance block.
// They expect signals named clock and reset in the calling scope.
// ----------------------------------------------------------------------------
`ifndef GREAT_CIRCLE_DISTANCE_TOP_MACROS_SVH
`define GREAT_CIRCLE_DISTANCE_TOP_MACROS_SVH

// same-cycle implication
`define GCD_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define GCD_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/gcdist_pkg.sv
// ----------------------------------------------------------------------------
// gcdist_pkg
// Types, widths and CORDIC constants of the great-circle distance block.
// ----------------------------------------------------------------------------
package gcdist_pkg;

   localparam int LAT_W    = 24;
   localparam int LON_W    = 26;
   localparam int DIST_W   = 25;
   localparam int RADIUS_W = 23;
   localparam int STEPS    = 28;

   typedef logic signed [31:0] q28_type;

   localparam logic [RADIUS_W-1:0] RADIUS_RST = 23'd6544968;
   localparam q28_type KINV_Q28 = 32'sd163008218;

   // long division of non-negative constants, shift and subtract
   function automatic longint cdiv(longint n, longint d);
      longint q;
      longint r;
      q = 0;
      r = 0;
      for (int b = 62; b >= 0; b--) begin
         r = (r << 1) | ((n >> b) & longint'(1));
         if (r >= d) begin
            r = r - d;
            q = q | (longint'(1) << b);
         end
      end
      return q;
   endfunction

   // Machin terms, Q40, truncating series
   function automatic longint atan_inv5_q40();
      longint p;
      longint sum;
      longint k;
      p   = cdiv(longint'(1) << 40, 5);
      sum = 0;
      k   = 0;
      while (p > 0) begin
         sum = k[0] ? sum - cdiv(p, 2 * k + 1) : sum + cdiv(p, 2 * k + 1);
         p   = cdiv(p, 25);
         k   = k + 1;
      end
      return sum;
   endfunction

   function automatic longint atan_inv239_q40();
      longint p;
      longint sum;
      longint k;
      p   = cdiv(longint'(1) << 40, 239);
      sum = 0;
      k   = 0;
      while (p > 0) begin
         sum = k[0] ? sum - cdiv(p, 2 * k + 1) : sum + cdiv(p, 2 * k + 1);
         p   = cdiv(p, 57121);
         k   = k + 1;
      end
      return sum;
   endfunction

   function automatic longint atan_pow2_q40(int i);
      longint sum;
      longint t;
      int k;
      sum = 0;
      k   = 0;
      while (i * (2 * k + 1) <= 40) begin
         t   = cdiv(longint'(1) << (40 - i * (2 * k + 1)), longint'(2 * k + 1));
         sum = k[0] ? sum - t : sum + t;
         k   = k + 1;
      end
      return sum;
   endfunction

   localparam longint PI4_Q40 = 4 * atan_inv5_q40() - atan_inv239_q40();
   localparam q28_type PI_Q28      = 32'((4 * PI4_Q40 + 2048) >>> 12);
   localparam q28_type HALF_PI_Q28 = 32'((2 * PI4_Q40 + 2048) >>> 12);
   localparam longint  PI180_Q32   = ((4 * PI4_Q40) / 180 + 128) >>> 8;

   function automatic q28_type atan_q28(int i);
      longint v;
      if (i == 0) begin
         v = PI4_Q40;
      end else begin
         v = atan_pow2_q40(i);
      end
      return 32'((v + 2048) >>> 12);
   endfunction

   // Q28 product, rounded to nearest, halves away from zero
   function automatic q28_type mul_q28(q28_type a, q28_type b);
      logic [31:0] ua;
      logic [31:0] ub;
      logic [63:0] p;
      logic [31:0] m;
      ua = a[31] ? 32'(-a) : 32'(a);
      ub = b[31] ? 32'(-b) : 32'(b);
      p  = 64'(ua) * 64'(ub) + (64'd1 << 27);
      m  = p[59:28];
      return (a[31] ^ b[31]) ? -$signed(m) : $signed(m);
   endfunction

endpackage

>>> hdl/gcdist_req_if.sv
// ----------------------------------------------------------------------------
// gcdist_req_if
// Point-pair channel: two latitudes and a longitude difference.
// ----------------------------------------------------------------------------
interface gcdist_req_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [gcdist_pkg::LAT_W-1:0]   lat_a;
   logic signed [gcdist_pkg::LAT_W-1:0]   lat_b;
   logic signed [gcdist_pkg::LON_W-1:0]   lon_diff;

   modport source (output valid, lat_a, lat_b, lon_diff, input ready);
   modport sink   (input valid, lat_a, lat_b, lon_diff, output ready);
endinterface

>>> hdl/gcdist_rsp_if.sv
// ----------------------------------------------------------------------------
// gcdist_rsp_if
// Distance result channel.
// ----------------------------------------------------------------------------
interface gcdist_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [gcdist_pkg::DIST_W-1:0] distance;

   modport source (output valid, distance, input ready);
   modport sink   (input valid, distance, output ready);
endinterface

>>> hdl/gcdist_csr_if.sv
// ----------------------------------------------------------------------------
// gcdist_csr_if
// Register write channel for the sphere radius.
// ----------------------------------------------------------------------------
interface gcdist_csr_if;
   logic                            valid;
   logic                            ready;
   logic [gcdist_pkg::RADIUS_W-1:0] sphere_radius;

   modport source (output valid, sphere_radius, input ready);
   modport sink   (input valid, sphere_radius, output ready);
endinterface

>>> hdl/great_circle_distance_top.sv
// ----------------------------------------------------------------------------
// great_circle_distance_top
// Fully pipelined great-circle distance: CORDIC sin/cos, vector products,
// pipelined square root, CORDIC atan2 and radius scaling.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch : one point pair per transfer (lat_a, lat_b, lon_diff in degrees
//            scaled by 2^ANGLE_FRAC_BITS, any value; angles wrap mod 360).
//   rsp_ch : one distance per pair, units of 1/1024 km, saturating at
//            2^25-1, in the order the pairs arrived.
//   csr_ch : writes sphere_radius; always ready. Write only while idle.
// The pipeline is 101 register stages deep; rsp valid comes from the last
// stage, so each result passes through all of them after its req transfer.
// Throughput is one pair per cycle: every stage is a register and an item
// enters each cycle while the output flows. The depth comes from the
// 28-stage sin/cos rotation (three lanes side by side), the 31-stage root
// and the 28-stage atan2 vectoring, plus 14 stages of reduction and products.
// Reset clears all valid bits and loads the default radius (6391.57 km).
// When the receiver stalls with a result waiting, the whole pipeline holds
// in place and req_ch.ready drops in the same cycle; nothing is lost.
// ----------------------------------------------------------------------------
module great_circle_distance_top #(
   parameter int ANGLE_FRAC_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   gcdist_req_if.sink        req_ch,
   gcdist_rsp_if.source      rsp_ch,
   gcdist_csr_if.sink        csr_ch
);

`include "great_circle_distance_top_macros.svh"

   localparam int STEPS = gcdist_pkg::STEPS;
   localparam int LAT   = 101;            // register stages, input to output
   localparam int ST_ANG = LAT - 3;       // stage holding the clamped angle

   // ------------------------------------------------------------------
   // Angle reduction constants
   // ------------------------------------------------------------------
   localparam longint FULL    = longint'(360) << ANGLE_FRAC_BITS;
   localparam longint HALF    = longint'(180) << ANGLE_FRAC_BITS;
   localparam longint QUARTER = longint'(90) << ANGLE_FRAC_BITS;
   localparam longint OFF_M   = (longint'(1) << 25) / FULL + 1;
   localparam longint OFFSET  = OFF_M * FULL;        // makes every input >= 0
   localparam int     U_W     = $clog2(OFFSET + (longint'(1) << 25));
   localparam longint RECIP   = (longint'(1) << U_W) / FULL;
   localparam int     R_W     = $clog2(RECIP + 1);
   localparam int     P_W     = U_W + R_W;
   localparam int     FULL_W2 = $clog2(2 * FULL);
   localparam int     W_MX    = (U_W > FULL_W2) ? U_W : FULL_W2;
   localparam int     RED_W   = FULL_W2 + 1;
   localparam int     SH      = ANGLE_FRAC_BITS + 4;
   localparam int     MW      = RED_W + 28;

   localparam logic signed [RED_W-1:0] FULL_S    = RED_W'(FULL);
   localparam logic signed [RED_W-1:0] HALF_S    = RED_W'(HALF);
   localparam logic signed [RED_W-1:0] QUARTER_S = RED_W'(QUARTER);

   localparam gcdist_pkg::q28_type PI_Q28      = gcdist_pkg::PI_Q28;
   localparam gcdist_pkg::q28_type HALF_PI_Q28 = gcdist_pkg::HALF_PI_Q28;

   // ------------------------------------------------------------------
   // Flow control: one global advance, valid bits shift alongside data
   // ------------------------------------------------------------------
   logic            adv;
   logic [LAT-1:0]  vld_ff;
   logic [LAT-1:0]  vld_in;

   assign adv          = !vld_ff[LAT-1] || rsp_ch.ready;
   assign req_ch.ready = adv;
   assign vld_in       = {vld_ff[LAT-2:0], req_ch.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   // ------------------------------------------------------------------
   // Radius register
   // ------------------------------------------------------------------
   logic [gcdist_pkg::RADIUS_W-1:0] radius_ff;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= gcdist_pkg::RADIUS_RST;
      end else if (csr_ch.valid) begin
         radius_ff <= csr_ch.sphere_radius;
      end
   end

   // ------------------------------------------------------------------
   // Three sin/cos lanes: lat_a, lat_b, lon_diff
   // ------------------------------------------------------------------
   logic signed [25:0]        deg [3];
   logic [U_W-1:0]            u_ff [3];
   logic [P_W-1:0]            prod_ff [3];
   logic [FULL_W2-1:0]        r0_ff [3];
   logic signed [RED_W-1:0]   rs_ff [3];
   logic                      rneg_ff [3];
   gcdist_pkg::q28_type       cx_ff [3][STEPS+1];
   gcdist_pkg::q28_type       cy_ff [3][STEPS+1];
   gcdist_pkg::q28_type       cz_ff [3][STEPS+1];
   logic                      cn_ff [3][STEPS+1];
   gcdist_pkg::q28_type       cos_ff [3];
   gcdist_pkg::q28_type       sin_ff [3];

   assign deg[0] = {{2{req_ch.lat_a[23]}}, req_ch.lat_a};
   assign deg[1] = {{2{req_ch.lat_b[23]}}, req_ch.lat_b};
   assign deg[2] = req_ch.lon_diff;

   for (genvar l = 0; l < 3; l++) begin : g_lane
      logic signed [U_W:0]     u_s;
      logic [U_W-1:0]          u_in;
      logic [R_W-1:0]          q_est;
      logic [W_MX-1:0]         diff;
      logic [FULL_W2-1:0]      r1;
      logic signed [RED_W-1:0] rs_a;
      logic signed [RED_W-1:0] rs_in;
      logic                    rneg_in;
      logic [RED_W-1:0]        mag;
      logic [MW-1:0]           mprod;
      logic [MW-1:0]           mshift;
      gcdist_pkg::q28_type     zmag;

      // R1: offset to non-negative, estimate quotient by reciprocal
      assign u_s  = {{(U_W + 1 - 26){deg[l][25]}}, deg[l]} + (U_W + 1)'(OFFSET);
      assign u_in = u_s[U_W-1:0];

      always_ff @(posedge clock) begin
         if (adv) begin
            u_ff[l]    <= u_in;
            prod_ff[l] <= P_W'(u_in) * P_W'(RECIP);
         end
      end

      // R2: remainder, within [0, 2*FULL)
      assign q_est = prod_ff[l][P_W-1:U_W];
      assign diff  = W_MX'(u_ff[l]) - W_MX'(q_est) * W_MX'(FULL);

      always_ff @(posedge clock) begin
         if (adv) begin
            r0_ff[l] <= diff[FULL_W2-1:0];
         end
      end

      // R3: final correction, wrap to [-180,180), fold beyond +-90
      always_comb begin
         r1      = (r0_ff[l] >= FULL_W2'(FULL)) ? r0_ff[l] - FULL_W2'(FULL) : r0_ff[l];
         rs_a    = $signed({1'b0, r1});
         rneg_in = 1'b0;
         if (rs_a >= HALF_S) begin
            rs_a = rs_a - FULL_S;
         end
         rs_in = rs_a;
         if (rs_a > QUARTER_S) begin
            rs_in   = rs_a - HALF_S;
            rneg_in = 1'b1;
         end else if (rs_a < -QUARTER_S) begin
            rs_in   = rs_a + HALF_S;
            rneg_in = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rs_ff[l]   <= rs_in;
            rneg_ff[l] <= rneg_in;
         end
      end

      // R4: degrees to radians, Q28
      assign mag    = rs_ff[l][RED_W-1] ? RED_W'(-rs_ff[l]) : RED_W'(rs_ff[l]);
      assign mprod  = MW'(mag) * MW'(gcdist_pkg::PI180_Q32) + (MW'(1) << (SH - 1));
      assign mshift = mprod >> SH;
      assign zmag   = $signed(mshift[31:0]);

      always_ff @(posedge clock) begin
         if (adv) begin
            cx_ff[l][0] <= gcdist_pkg::KINV_Q28;
            cy_ff[l][0] <= '0;
            cz_ff[l][0] <= rs_ff[l][RED_W-1] ? -zmag : zmag;
            cn_ff[l][0] <= rneg_ff[l];
         end
      end

      // rotation stages
      for (genvar i = 0; i < STEPS; i++) begin : g_rot
         localparam gcdist_pkg::q28_type AT = gcdist_pkg::atan_q28(i);
         gcdist_pkg::q28_type dx;
         gcdist_pkg::q28_type dy;
         assign dx = cy_ff[l][i] >>> i;
         assign dy = cx_ff[l][i] >>> i;
         always_ff @(posedge clock) begin
            if (adv) begin
               if (!cz_ff[l][i][31]) begin
                  cx_ff[l][i+1] <= cx_ff[l][i] - dx;
                  cy_ff[l][i+1] <= cy_ff[l][i] + dy;
                  cz_ff[l][i+1] <= cz_ff[l][i] - AT;
               end else begin
                  cx_ff[l][i+1] <= cx_ff[l][i] + dx;
                  cy_ff[l][i+1] <= cy_ff[l][i] - dy;
                  cz_ff[l][i+1] <= cz_ff[l][i] + AT;
               end
               cn_ff[l][i+1] <= cn_ff[l][i];
            end
         end
      end

      // quadrant restore
      always_ff @(posedge clock) begin
         if (adv) begin
            cos_ff[l] <= cn_ff[l][STEPS] ? -cx_ff[l][STEPS] : cx_ff[l][STEPS];
            sin_ff[l] <= cn_ff[l][STEPS] ? -cy_ff[l][STEPS] : cy_ff[l][STEPS];
         end
      end
   end

   // ------------------------------------------------------------------
   // Unit vectors, cross and dot products
   // ------------------------------------------------------------------
   gcdist_pkg::q28_type m1_x1_ff, m1_z1_ff, m1_x2_ff, m1_y2_ff, m1_z2_ff;
   gcdist_pkg::q28_type p1_ff, p2_ff, p3_ff, p4_ff, p5_ff, p6_ff;
   gcdist_pkg::q28_type xp, yp, zp;
   logic [30:0]         ax_ff, ay_ff, az_ff;
   gcdist_pkg::q28_type m3_cos_ff, m4_cos_ff;
   logic [61:0]         sx_ff, sy_ff, sz_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         m1_x1_ff <= cos_ff[0];
         m1_z1_ff <= sin_ff[0];
         m1_x2_ff <= gcdist_pkg::mul_q28(cos_ff[1], cos_ff[2]);
         m1_y2_ff <= gcdist_pkg::mul_q28(cos_ff[1], sin_ff[2]);
         m1_z2_ff <= sin_ff[1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p1_ff <= gcdist_pkg::mul_q28(m1_z1_ff, m1_y2_ff);
         p2_ff <= gcdist_pkg::mul_q28(m1_z1_ff, m1_x2_ff);
         p3_ff <= gcdist_pkg::mul_q28(m1_x1_ff, m1_z2_ff);
         p4_ff <= gcdist_pkg::mul_q28(m1_x1_ff, m1_y2_ff);
         p5_ff <= gcdist_pkg::mul_q28(m1_x1_ff, m1_x2_ff);
         p6_ff <= gcdist_pkg::mul_q28(m1_z1_ff, m1_z2_ff);
      end
   end

   assign xp = -p1_ff;
   assign yp = p2_ff - p3_ff;
   assign zp = p4_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         ax_ff     <= xp[31] ? 31'(-xp) : 31'(xp);
         ay_ff     <= yp[31] ? 31'(-yp) : 31'(yp);
         az_ff     <= zp[31] ? 31'(-zp) : 31'(zp);
         m3_cos_ff <= p5_ff + p6_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sx_ff     <= 62'(ax_ff) * 62'(ax_ff);
         sy_ff     <= 62'(ay_ff) * 62'(ay_ff);
         sz_ff     <= 62'(az_ff) * 62'(az_ff);
         m4_cos_ff <= m3_cos_ff;
      end
   end

   // ------------------------------------------------------------------
   // Square root of the Q56 norm, one result bit per stage
   // ------------------------------------------------------------------
   localparam int SQ_N = 31;

   logic [61:0]         sq_rem_ff  [SQ_N+1];
   logic [30:0]         sq_root_ff [SQ_N+1];
   gcdist_pkg::q28_type sq_cos_ff  [SQ_N+1];

   always_ff @(posedge clock) begin
      if (adv) begin
         sq_rem_ff[0]  <= sx_ff + sy_ff + sz_ff;
         sq_root_ff[0] <= '0;
         sq_cos_ff[0]  <= m4_cos_ff;
      end
   end

   for (genvar j = 0; j < SQ_N; j++) begin : g_sqrt
      localparam int B = SQ_N - 1 - j;
      logic [61:0] delta;
      assign delta = (62'(sq_root_ff[j]) << (B + 1)) + (62'd1 << (2 * B));
      always_ff @(posedge clock) begin
         if (adv) begin
            if (sq_rem_ff[j] >= delta) begin
               sq_rem_ff[j+1]  <= sq_rem_ff[j] - delta;
               sq_root_ff[j+1] <= sq_root_ff[j] | (31'd1 << B);
            end else begin
               sq_rem_ff[j+1]  <= sq_rem_ff[j];
               sq_root_ff[j+1] <= sq_root_ff[j];
            end
            sq_cos_ff[j+1] <= sq_cos_ff[j];
         end
      end
   end

   // ------------------------------------------------------------------
   // atan2(sin, cos) by CORDIC vectoring
   // ------------------------------------------------------------------
   logic signed [35:0]  ax36_ff [STEPS+1];
   logic signed [35:0]  ay36_ff [STEPS+1];
   gcdist_pkg::q28_type az_acc_ff [STEPS+1];
   logic [STEPS:0]      sp_ff;       // zero cross product
   logic [STEPS:0]      spneg_ff;    // and negative dot product
   logic [29:0]         ang_ff;

   logic signed [35:0]  s36;
   logic signed [35:0]  c36;

   assign s36 = $signed({5'd0, sq_root_ff[SQ_N]});
   assign c36 = 36'(sq_cos_ff[SQ_N]);

   always_ff @(posedge clock) begin
      if (adv) begin
         if (!sq_cos_ff[SQ_N][31]) begin
            ax36_ff[0]   <= c36;
            ay36_ff[0]   <= s36;
            az_acc_ff[0] <= '0;
         end else begin
            ax36_ff[0]   <= s36;
            ay36_ff[0]   <= -c36;
            az_acc_ff[0] <= HALF_PI_Q28;
         end
         sp_ff[0]    <= (sq_root_ff[SQ_N] == '0);
         spneg_ff[0] <= sq_cos_ff[SQ_N][31];
      end
   end

   for (genvar i = 0; i < STEPS; i++) begin : g_vec
      localparam gcdist_pkg::q28_type AT = gcdist_pkg::atan_q28(i);
      logic signed [35:0] dx;
      logic signed [35:0] dy;
      assign dx = ay36_ff[i] >>> i;
      assign dy = ax36_ff[i] >>> i;
      always_ff @(posedge clock) begin
         if (adv) begin
            if (!ay36_ff[i][35]) begin
               ax36_ff[i+1]   <= ax36_ff[i] + dx;
               ay36_ff[i+1]   <= ay36_ff[i] - dy;
               az_acc_ff[i+1] <= az_acc_ff[i] + AT;
            end else begin
               ax36_ff[i+1]   <= ax36_ff[i] - dx;
               ay36_ff[i+1]   <= ay36_ff[i] + dy;
               az_acc_ff[i+1] <= az_acc_ff[i] - AT;
            end
            sp_ff[i+1]    <= sp_ff[i];
            spneg_ff[i+1] <= spneg_ff[i];
         end
      end
   end

   // special cases and clamp to [0, pi]
   always_ff @(posedge clock) begin
      if (adv) begin
         if (sp_ff[STEPS]) begin
            ang_ff <= spneg_ff[STEPS] ? 30'(PI_Q28) : '0;
         end else if (az_acc_ff[STEPS][31]) begin
            ang_ff <= '0;
         end else if (az_acc_ff[STEPS] > PI_Q28) begin
            ang_ff <= 30'(PI_Q28);
         end else begin
            ang_ff <= 30'(az_acc_ff[STEPS]);
         end
      end
   end

   // ------------------------------------------------------------------
   // Scale by radius, round, saturate
   // ------------------------------------------------------------------
   logic [53:0]             dprod_ff;
   logic [25:0]             dq;
   logic [gcdist_pkg::DIST_W-1:0] dist_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         dprod_ff <= 54'(ang_ff) * 54'(radius_ff) + (54'd1 << 27);
      end
   end

   assign dq = dprod_ff[53:28];

   always_ff @(posedge clock) begin
      if (adv) begin
         dist_ff <= dq[25] ? '1 : dq[24:0];
      end
   end

   assign rsp_ch.valid    = vld_ff[LAT-1];
   assign rsp_ch.distance = dist_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   `GCD_ASSERT_NXT(a_stall_hold, !adv, $stable(vld_ff), "pipeline moved during stall")
   `GCD_ASSERT_NXT(a_out_fill, adv && vld_ff[LAT-2], rsp_ch.valid, "result lost at output")
   `GCD_ASSERT_IMP(a_ang_range, vld_ff[ST_ANG], ang_ff <= 30'(PI_Q28), "angle above pi")

endmodule
